// ===== hdl/mfre_pkg.sv =====
// shared types and constants for the monochrome frame buffer raster engine
package mfre_pkg;

   localparam int DefScreenWidth  = 128;
   localparam int DefScreenHeight = 64;
   localparam int ChunkBits       = 128;

   localparam logic [2:0] CMD_SET_POINT  = 3'd0;
   localparam logic [2:0] CMD_CLEAR_AREA = 3'd1;
   localparam logic [2:0] CMD_INVERT     = 3'd2;
   localparam logic [2:0] CMD_LINE       = 3'd3;
   localparam logic [2:0] CMD_READ_AREA  = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OFFSCREEN = 2'd1;
   localparam logic [1:0] ST_UNSUPP    = 2'd2;
   localparam logic [1:0] ST_REVERSED  = 2'd3;

   // row operations the controller asks of the datapath
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;   // read-modify-write of one row
   localparam logic [1:0] OP_READ  = 2'd2;   // marks a row end during readout; the datapath does not act on it

   typedef struct packed {
      logic       load;       // capture command fields
      logic       row_start;  // issue memory read of current row
      logic [1:0] op;         // act on the row data now available
      logic       emit;       // send a result beat
      logic       emit_last;
      logic [1:0] emit_status;
      logic       clear_run;  // reset-time clearing pass write
   } ctl_type;

   typedef struct packed {
      logic [1:0] check;      // status decided from the request fields, captured at load
      logic       is_read;
      logic       row_done;   // current row is the bottom row
      logic       col_done;   // read: last column of the row
      logic       chunk_full;
      logic       clear_done;
   } sts_type;

endpackage

// ===== hdl/mfre_datapath.sv =====
// row store, coordinate registers and readout chunk assembly
module mfre_datapath
   import mfre_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DefScreenWidth,
   parameter int SCREEN_HEIGHT = DefScreenHeight
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [2:0]   req_command,
   input  logic [15:0]  req_x_first,
   input  logic [15:0]  req_y_first,
   input  logic [15:0]  req_x_second,
   input  logic [15:0]  req_y_second,
   input  logic [7:0]   req_pixel_value,
   input  ctl_type      ctl,
   input  logic         rd_step,      // read: advance one column
   output sts_type      sts,
   output logic [63:0]  bits_upper,
   output logic [63:0]  bits_lower,
   output logic [7:0]   bit_count
);

   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);

   logic [SCREEN_WIDTH-1:0] mem [SCREEN_HEIGHT];
   logic [SCREEN_WIDTH-1:0] row_q_ff;
   logic [SCREEN_WIDTH-1:0] row_new;

   logic [2:0]  cmd_ff;
   logic [XW-1:0] xl_ff, xr_ff, xc_ff;
   logic [YW-1:0] yt_ff, yb_ff, yc_ff;
   logic        pv_ff;
   logic [1:0]  check_ff;
   logic [127:0] chunk_ff;
   logic [7:0]   fill_ff;
   logic [YW-1:0] clr_ff;

   logic signed [15:0] x1, y1, x2, y2;
   logic on1, on2, pt;
   logic [1:0] check_in;
   logic signed [15:0] xl, xr, yt, yb;

   assign x1 = req_x_first;
   assign y1 = req_y_first;
   assign x2 = req_x_second;
   assign y2 = req_y_second;
   assign on1 = x1 >= 0 && y1 >= 0 && x1 < SCREEN_WIDTH && y1 < SCREEN_HEIGHT;
   assign on2 = x2 >= 0 && y2 >= 0 && x2 < SCREEN_WIDTH && y2 < SCREEN_HEIGHT;
   assign pt = req_command == CMD_SET_POINT;

   always_comb begin
      xl = x1; xr = x2; yt = y1; yb = y2;
      if (pt) begin
         xr = x1; yb = y1;
      end else if (req_command == CMD_LINE) begin
         if (x1 > x2) begin xl = x2; xr = x1; end
         if (y1 > y2) begin yt = y2; yb = y1; end
      end
      if (req_command > CMD_READ_AREA) check_in = ST_UNSUPP;
      else if (!on1 || (!pt && !on2)) check_in = ST_OFFSCREEN;
      else if (req_command == CMD_LINE && x1 != x2 && y1 != y2) check_in = ST_UNSUPP;
      else if (!pt && req_command != CMD_LINE && (x1 > x2 || y1 > y2))
         check_in = ST_REVERSED;
      else check_in = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_command;
         xl_ff    <= xl[XW-1:0];
         xr_ff    <= xr[XW-1:0];
         xc_ff    <= xl[XW-1:0];
         yt_ff    <= yt[YW-1:0];
         yb_ff    <= yb[YW-1:0];
         yc_ff    <= yt[YW-1:0];
         pv_ff    <= req_pixel_value != 8'd0;
         check_ff <= check_in;
      end
      if (ctl.row_start) row_q_ff <= mem[yc_ff];
      if (ctl.op == OP_WRITE) begin
         mem[yc_ff] <= row_new;
         yc_ff <= yc_ff + 1'b1;
      end
      if (ctl.clear_run) mem[clr_ff] <= '0;
      if (rd_step) begin
         if (xc_ff == xr_ff) begin
            xc_ff <= xl_ff;
            yc_ff <= yc_ff + 1'b1;
         end else begin
            xc_ff <= xc_ff + 1'b1;
         end
      end
   end

   // new row value: the command applied within the captured span, pixel x at bit x
   always_comb begin
      for (int i = 0; i < SCREEN_WIDTH; i++) begin
         if (i >= xl_ff && i <= xr_ff) begin
            case (cmd_ff)
               CMD_SET_POINT:  row_new[i] = pv_ff;
               CMD_CLEAR_AREA: row_new[i] = 1'b0;
               CMD_INVERT:     row_new[i] = ~row_q_ff[i];
               default:        row_new[i] = 1'b1;
            endcase
         end else begin
            row_new[i] = row_q_ff[i];
         end
      end
   end

   // chunk assembly, stream bit 0 at the msb
   always_ff @(posedge clock) begin
      if (reset || ctl.load || ctl.emit) begin
         chunk_ff <= '0;
         fill_ff  <= '0;
      end else if (rd_step) begin
         chunk_ff[7'd127 - fill_ff[6:0]] <= row_q_ff[xc_ff];
         fill_ff <= fill_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (ctl.clear_run) clr_ff <= clr_ff + 1'b1;
   end

   assign sts.check      = check_ff;
   assign sts.is_read    = cmd_ff == CMD_READ_AREA;
   assign sts.row_done   = yc_ff == yb_ff;
   assign sts.col_done   = xc_ff == xr_ff;
   assign sts.chunk_full = fill_ff == 8'd127;
   assign sts.clear_done = clr_ff == YW'(SCREEN_HEIGHT - 1);

   assign bits_upper = chunk_ff[127:64];
   assign bits_lower = chunk_ff[63:0];
   assign bit_count  = fill_ff;

endmodule

// ===== hdl/mfre_control.sv =====
// command sequencer for the raster engine
module mfre_control
   import mfre_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output logic    busy,
   output ctl_type ctl,
   output logic    rd_step
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       last_ff, last_in;
   // a chunk may end mid-row or at a row end; row end needs a refetch
   logic       refetch_ff;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      ctl      = '0;
      rd_step  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear_run = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.check != ST_OK) begin
               ctl.emit = 1'b1; ctl.emit_last = 1'b1; ctl.emit_status = sts.check;
               state_in = S_IDLE;
            end else begin
               ctl.row_start = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // row data now registered
            state_in = sts.is_read ? S_READ : S_WRITE;
         end
         S_WRITE: begin
            ctl.op = OP_WRITE;
            if (sts.row_done) begin
               ctl.emit = 1'b1; ctl.emit_last = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_READ: begin
            rd_step = 1'b1;
            last_in = sts.col_done && sts.row_done;
            if (sts.chunk_full || last_in) state_in = S_FLUSH;
            else if (sts.col_done) begin
               ctl.op = OP_READ;
               state_in = S_CHECK;
            end
         end
         S_FLUSH: begin
            ctl.emit = 1'b1; ctl.emit_last = last_ff;
            if (last_ff) state_in = S_IDLE;
            else if (refetch_ff) state_in = S_CHECK;
            else state_in = S_READ;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         last_ff    <= 1'b0;
         refetch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         if (state_ff == S_READ) refetch_ff <= sts.col_done;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

// ===== hdl/mono_framebuffer_raster_engine_unit.sv =====
// top level of the monochrome frame buffer raster engine
// usage:
//   a command beat is taken when start is high and busy is low; the fields
//   sit on the req_ ports. each result beat appears for one cycle with
//   rsp_valid high and cannot be held off by the receiver.
//   rejected commands answer with a single beat, sent from the check state.
//   set point, line, clear and invert walk the rows of the span; each row
//   is fetched, registered and written back before the next one.
//   a readout takes one pixel per cycle, paused for each chunk beat and
//   for the row fetch of each row; a full screen readout gives 64 beats.
//   rsp_last marks the final beat of a command; busy falls with it.
//   after reset the store is swept to zero one row a cycle, every row,
//   with busy high; no command is taken during that pass.
//   the row store is one memory with one read port and two write addresses.
module mono_framebuffer_raster_engine_unit
   import mfre_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DefScreenWidth,
   parameter int SCREEN_HEIGHT = DefScreenHeight
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_x_first,
   input  logic [15:0] req_y_first,
   input  logic [15:0] req_x_second,
   input  logic [15:0] req_y_second,
   input  logic [7:0]  req_pixel_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_bits_upper,
   output logic [63:0] rsp_bits_lower,
   output logic [7:0]  rsp_bit_count,
   output logic        rsp_last
);

   ctl_type ctl;
   sts_type sts;
   logic    rd_step;
   logic [63:0] up, lo;
   logic [7:0]  cnt;

   mfre_control u_ctl (
      .clock, .reset, .start, .sts, .busy, .ctl, .rd_step
   );

   mfre_datapath #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
      .clock, .reset, .req_command, .req_x_first, .req_y_first, .req_x_second,
      .req_y_second, .req_pixel_value, .ctl, .rd_step, .sts,
      .bits_upper(up), .bits_lower(lo), .bit_count(cnt)
   );

   logic rd_beat;
   assign rd_beat = ctl.emit && sts.is_read && sts.check == ST_OK;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= ctl.emit;
      rsp_status     <= ctl.emit_status;
      rsp_last       <= ctl.emit_last;
      rsp_bits_upper <= rd_beat ? up : 64'd0;
      rsp_bits_lower <= rd_beat ? lo : 64'd0;
      rsp_bit_count  <= rd_beat ? cnt : 8'd0;
   end

endmodule

// ===== hdl/mfre_checker.sv =====
// port-level checks for the raster engine, bound to the top level
module mfre_checker
   import mfre_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_bit_count,
   input logic       rsp_last
);

   a_no_take_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("command not taken");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_bit_count == 8'd0)
      else $error("error beat carries data");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bit_count <= 8'd128) else $error("chunk too long");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_valid) else $error("beat while idle");

endmodule

bind mono_framebuffer_raster_engine_unit mfre_checker u_chk (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_status, .rsp_bit_count, .rsp_last
);

// ===== sim/mono_framebuffer_raster_engine_unit_tb.sv =====
// self-checking testbench for the monochrome frame buffer raster engine
module mono_framebuffer_raster_engine_unit_tb
   import mfre_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Width  = DefScreenWidth;
   localparam int Height = DefScreenHeight;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] upper;
      logic [63:0] lower;
      logic [7:0]  count;
      logic        last;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command = '0;
   logic [15:0] req_x_first = '0;
   logic [15:0] req_y_first = '0;
   logic [15:0] req_x_second = '0;
   logic [15:0] req_y_second = '0;
   logic [7:0]  req_pixel_value = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_bits_upper;
   logic [63:0] rsp_bits_lower;
   logic [7:0]  rsp_bit_count;
   logic        rsp_last;

   logic  screen [Height][Width];
   beat_type pending_beats[$];
   int    errors = 0;
   int    idle_pct = 0;

   always #4 clock = ~clock;

   mono_framebuffer_raster_engine_unit u_top (.*);

   function automatic bit on_screen(int x, int y);
      return x >= 0 && y >= 0 && x < Width && y < Height;
   endfunction

   function automatic void push_status(logic [1:0] st);
      beat_type b;
      b.status = st; b.upper = '0; b.lower = '0; b.count = '0; b.last = 1'b1;
      pending_beats.push_back(b);
   endfunction

   // applies one command to the shadow screen and queues its beats
   function automatic void raster_predict(logic [2:0] cmd, logic [15:0] ax, logic [15:0] ay,
                                          logic [15:0] bx, logic [15:0] by, logic [7:0] pv);
      int x1, y1, x2, y2, total, sent, fill;
      logic [127:0] chunk;
      beat_type b;
      x1 = int'($signed(ax)); y1 = int'($signed(ay));
      x2 = int'($signed(bx)); y2 = int'($signed(by));
      if (cmd > CMD_READ_AREA) begin
         push_status(ST_UNSUPP);
         return;
      end
      if (cmd == CMD_SET_POINT) begin
         if (!on_screen(x1, y1)) begin
            push_status(ST_OFFSCREEN);
            return;
         end
         screen[y1][x1] = (pv != 0);
         push_status(ST_OK);
         return;
      end
      if (!on_screen(x1, y1) || !on_screen(x2, y2)) begin
         push_status(ST_OFFSCREEN);
         return;
      end
      if (cmd == CMD_LINE) begin
         if (x1 == x2) begin
            for (int y = (y1 < y2 ? y1 : y2); y <= (y1 < y2 ? y2 : y1); y++)
               screen[y][x1] = 1'b1;
         end else if (y1 == y2) begin
            for (int x = (x1 < x2 ? x1 : x2); x <= (x1 < x2 ? x2 : x1); x++)
               screen[y1][x] = 1'b1;
         end else begin
            push_status(ST_UNSUPP);
            return;
         end
         push_status(ST_OK);
         return;
      end
      if (x1 > x2 || y1 > y2) begin
         push_status(ST_REVERSED);
         return;
      end
      if (cmd != CMD_READ_AREA) begin
         for (int y = y1; y <= y2; y++)
            for (int x = x1; x <= x2; x++)
               screen[y][x] = (cmd == CMD_CLEAR_AREA) ? 1'b0 : ~screen[y][x];
         push_status(ST_OK);
         return;
      end
      total = (x2 - x1 + 1) * (y2 - y1 + 1);
      sent = 0; fill = 0; chunk = '0;
      for (int y = y1; y <= y2; y++)
         for (int x = x1; x <= x2; x++) begin
            chunk[127 - fill] = screen[y][x];
            fill++; sent++;
            if (fill == 128 || sent == total) begin
               b.status = ST_OK; b.upper = chunk[127:64]; b.lower = chunk[63:0];
               b.count = 8'(fill); b.last = (sent == total);
               pending_beats.push_back(b);
               fill = 0; chunk = '0;
            end
         end
   endfunction

   // one command beat, random idle cycles before it
   task automatic send_cmd(logic [2:0] cmd, int ax, int ay, int bx, int by, logic [7:0] pv);
      @(negedge clock);
      while ($urandom_range(99, 0) < idle_pct) @(negedge clock);
      start <= 1'b1;
      req_command <= cmd;
      req_x_first <= 16'(ax); req_y_first <= 16'(ay);
      req_x_second <= 16'(bx); req_y_second <= 16'(by);
      req_pixel_value <= pv;
      @(posedge clock);
      while (busy) @(posedge clock);
      raster_predict(cmd, 16'(ax), 16'(ay), 16'(bx), 16'(by), pv);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain;
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_beats.size() == 0) begin
            $display("%0t unexpected beat: status %0d count %0d", $time, rsp_status,
                     rsp_bit_count);
            errors++;
         end else begin
            beat_type e;
            e = pending_beats.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t status: expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_bits_upper !== e.upper) begin
               $display("%0t upper: expected %h actual %h", $time, e.upper, rsp_bits_upper);
               errors++;
            end
            if (rsp_bits_lower !== e.lower) begin
               $display("%0t lower: expected %h actual %h", $time, e.lower, rsp_bits_lower);
               errors++;
            end
            if (rsp_bit_count !== e.count) begin
               $display("%0t count: expected %0d actual %0d", $time, e.count, rsp_bit_count);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t last: expected %0d actual %0d", $time, e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   task automatic test_edges;
      send_cmd(CMD_READ_AREA, 0, 0, Width - 1, Height - 1, 8'd0);
      send_cmd(CMD_SET_POINT, 0, 0, 0, 0, 8'hff);
      send_cmd(CMD_SET_POINT, Width - 1, Height - 1, 0, 0, 8'h01);
      send_cmd(CMD_SET_POINT, 5, 5, 0, 0, 8'h80);
      send_cmd(CMD_SET_POINT, 5, 5, 0, 0, 8'h00);
      send_cmd(CMD_SET_POINT, -1, 0, 0, 0, 8'h01);
      send_cmd(CMD_SET_POINT, 0, -32768, 0, 0, 8'h01);
      send_cmd(CMD_SET_POINT, Width, 0, 0, 0, 8'h01);
      send_cmd(CMD_SET_POINT, 32767, Height, 0, 0, 8'h01);
      send_cmd(CMD_CLEAR_AREA, 0, 0, Width, 3, 8'd0);
      send_cmd(CMD_INVERT, 3, 2, 40, 20, 8'd0);
      send_cmd(CMD_INVERT, 10, 2, 9, 20, 8'd0);
      send_cmd(CMD_CLEAR_AREA, 3, 21, 40, 20, 8'd0);
      send_cmd(CMD_READ_AREA, 9, 9, 8, 9, 8'd0);
      send_cmd(CMD_LINE, 70, 60, 70, 1, 8'd0);
      send_cmd(CMD_LINE, 127, 33, 0, 33, 8'd0);
      send_cmd(CMD_LINE, 1, 1, 2, 2, 8'd0);
      send_cmd(CMD_LINE, 4, 4, 4, 4, 8'd0);
      send_cmd(CMD_CLEAR_AREA, 20, 10, 30, 12, 8'd0);
      send_cmd(3'd5, 0, 0, 0, 0, 8'd0);
      send_cmd(3'd6, 0, 0, 0, 0, 8'd0);
      send_cmd(3'd7, 0, 0, 0, 0, 8'd0);
      send_cmd(CMD_READ_AREA, 0, 0, Width - 1, Height - 1, 8'd0);
      send_cmd(CMD_READ_AREA, 60, 30, 60, 30, 8'd0);
   endtask

   task automatic random_coord(output int v, input int lim);
      case ($urandom_range(9, 0))
         0: v = int'($signed(16'($urandom())));
         1: v = $urandom_range(1) ? lim : -1;
         default: v = $urandom_range(lim - 1, 0);
      endcase
   endtask

   task automatic test_random(int count);
      int ax, ay, bx, by, t;
      logic [2:0] cmd;
      for (int i = 0; i < count; i++) begin
         cmd = ($urandom_range(19, 0) == 0) ? 3'($urandom_range(7, 5))
                                            : 3'($urandom_range(4, 0));
         random_coord(ax, Width); random_coord(ay, Height);
         // keep most areas small so readouts stay short
         if ($urandom_range(3, 0) == 0) begin
            random_coord(bx, Width); random_coord(by, Height);
         end else begin
            bx = ax + $urandom_range(12, 0); by = ay + $urandom_range(6, 0);
            if (bx >= Width) bx = Width - 1;
            if (by >= Height) by = Height - 1;
         end
         if (cmd == CMD_LINE && $urandom_range(3, 0) != 0) begin
            if ($urandom_range(1)) bx = ax; else by = ay;
         end
         if ($urandom_range(9, 0) == 0) begin
            t = ax; ax = bx; bx = t;
         end
         send_cmd(cmd, ax, ay, bx, by, 8'($urandom()));
      end
   endtask

   initial begin
      foreach (screen[y, x]) screen[y][x] = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct = 0;
      test_edges();
      test_random(34);
      idle_pct = 57;
      test_random(34);
      drain();
      // sender holds off until everything has come back
      test_random(34);
      idle_pct = 23;
      test_random(34);
      idle_pct = 0;
      send_cmd(CMD_READ_AREA, 0, 0, Width - 1, Height - 1, 8'd0);
      drain();
      repeat (300) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #60ms;
      $display("tb: failure");
      $finish;
   end

endmodule
